FILE: hdl/anxb_pkg.sv
// Shared types and constants for the Annex B NAL unit splitter.
// No dependencies; imported by every module of the block.
package anxb_pkg;

    localparam int LEN_W    = 28;
    localparam int ZCNT_W   = 3;
    localparam int PREFIX_W = 3;

    localparam logic [LEN_W-1:0]    MAX_LEN_RESET = 28'h800_0000;
    localparam logic [PREFIX_W-1:0] PREFIX_SHORT  = 3'd3;
    localparam logic [PREFIX_W-1:0] PREFIX_LONG   = 3'd4;
    localparam logic [7:0]          BYTE_ZERO     = 8'h00;
    localparam logic [7:0]          BYTE_ONE      = 8'h01;
    localparam logic [7:0]          TYPE_MASK     = 8'h1f;
    localparam logic [7:0]          FORBID_MASK   = 8'h80;

    // at most one command per accepted item: zero pushes, then the byte, then the tail
    typedef struct packed {
        logic [ZCNT_W-1:0] zeros;
        logic              push_b;
        logic [7:0]        data;
        logic              finish;
        logic              open_nal;
        logic              is_long;
        logic              garbage;
    } anxb_cmd_t;

endpackage

FILE: hdl/anxb_front.sv
// Front end: accepts stream bytes, tracks start-code zeros, issues commands.
// Depends on anxb_pkg.
module anxb_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // stream_byte
    input  logic                s_tlast,   // end_of_stream
    input  logic                q_full,
    output logic                q_wr,
    output anxb_pkg::anxb_cmd_t q_data
);
    import anxb_pkg::*;

    logic       inside_reg, inside_next;
    logic [1:0] zrun_reg, zrun_next;
    logic       drop_reg, drop_next;
    logic       accept;
    anxb_cmd_t  cmd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd         = '0;
        cmd.data    = s_tdata;
        cmd.garbage = drop_reg;
        inside_next = inside_reg;
        zrun_next   = zrun_reg;
        drop_next   = drop_reg;
        if (!inside_reg) begin
            if (s_tdata == BYTE_ZERO) begin
                if (zrun_reg != 2'd3) zrun_next = zrun_reg + 2'd1;
                else drop_next = 1'b1;
            end else if (s_tdata == BYTE_ONE && zrun_reg[1]) begin
                cmd.open_nal = 1'b1;
                cmd.is_long  = (zrun_reg == 2'd3);
                inside_next  = 1'b1;
                zrun_next    = 2'd0;
            end else begin
                drop_next = 1'b1;
                zrun_next = 2'd0;
            end
        end else begin
            if (s_tdata == BYTE_ZERO) begin
                if (zrun_reg != 2'd3) zrun_next = zrun_reg + 2'd1;
                else cmd.zeros = 3'd1;
            end else if (s_tdata == BYTE_ONE && zrun_reg[1]) begin
                cmd.finish   = 1'b1;
                cmd.open_nal = 1'b1;
                cmd.is_long  = (zrun_reg == 2'd3);
                drop_next    = 1'b0;
                zrun_next    = 2'd0;
            end else begin
                cmd.zeros  = {1'b0, zrun_reg};
                cmd.push_b = 1'b1;
                zrun_next  = 2'd0;
            end
        end
        if (s_tlast) begin
            if (inside_next) begin
                cmd.zeros  = cmd.zeros + {1'b0, zrun_next};
                cmd.finish = 1'b1;
            end
            inside_next = 1'b0;
            zrun_next   = 2'd0;
            drop_next   = 1'b0;
        end
    end

    assign q_data = cmd;
    assign q_wr   = accept && ((cmd.zeros != '0) || cmd.push_b || cmd.finish || cmd.open_nal);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
            zrun_reg   <= 2'd0;
            drop_reg   <= 1'b0;
        end else if (accept) begin
            inside_reg <= inside_next;
            zrun_reg   <= zrun_next;
            drop_reg   <= drop_next;
        end
    end

endmodule

FILE: hdl/anxb_queue.sv
// Small command queue between front and back end.
// Depends on anxb_pkg.
module anxb_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr,
    input  anxb_pkg::anxb_cmd_t wr_data,
    output logic                full,
    input  logic                rd,
    output logic                empty,
    output anxb_pkg::anxb_cmd_t rd_data
);
    import anxb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    anxb_cmd_t        entries [DEPTH];
    logic [PTR_W-1:0] wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = entries[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr) count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (do_wr) entries[wptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (do_wr) wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PTR_W'(1);
            if (do_rd) rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PTR_W'(1);
        end
    end

endmodule

FILE: hdl/anxb_back.sv
// Back end: runs queued commands one push per cycle unless the output stalls, holds
// the last byte, tracks header, length and prefix, and drives the output register. Uses anxb_pkg.
module anxb_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [anxb_pkg::LEN_W-1:0]          cfg_wdata,
    input  logic                                q_empty,
    input  anxb_pkg::anxb_cmd_t                 q_data,
    output logic                                q_rd,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          out_byte,
    output logic                                out_first,
    output logic                                out_last,
    output logic [anxb_pkg::LEN_W-1:0]          out_len,
    output logic [anxb_pkg::PREFIX_W-1:0]       out_prefix,
    output logic [7:0]                          out_header,
    output logic                                out_too_long,
    output logic                                out_garbage
);
    import anxb_pkg::*;

    logic [LEN_W-1:0]    max_reg;
    logic [ZCNT_W-1:0]   zdone_reg;
    logic                bdone_reg;
    logic [7:0]          held_reg;
    logic                held_v_reg;
    logic                hseen_reg;
    logic [7:0]          hbyte_reg;
    logic [PREFIX_W-1:0] prefix_reg;
    logic [LEN_W-1:0]    len_reg;
    logic                ovf_reg;
    logic                ov_reg;

    logic             can_go, step;
    logic             do_zero, do_b, do_tail, last_op, emit;
    logic             len_lt;
    logic [LEN_W-1:0] len_next;
    logic [7:0]       hdr_next;

    assign can_go  = !ov_reg || m_tready;
    assign step    = can_go && !q_empty;
    assign do_zero = (zdone_reg < q_data.zeros);
    assign do_b    = !do_zero && q_data.push_b && !bdone_reg;
    assign do_tail = !do_zero && !do_b;

    always_comb begin
        if (do_zero)
            last_op = (zdone_reg + ZCNT_W'(1) == q_data.zeros) && !q_data.push_b
                      && !q_data.finish && !q_data.open_nal;
        else if (do_b)
            last_op = !q_data.finish && !q_data.open_nal;
        else
            last_op = 1'b1;
    end

    assign q_rd     = step && last_op;
    assign emit     = held_v_reg && (do_zero || do_b || q_data.finish);
    assign len_lt   = (len_reg < max_reg);
    assign len_next = len_lt ? len_reg + LEN_W'(1) : len_reg;
    assign hdr_next = hseen_reg ? hbyte_reg : held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MAX_LEN_RESET;
        end else if (cfg_we) begin
            max_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zdone_reg  <= '0;
            bdone_reg  <= 1'b0;
            held_reg   <= BYTE_ZERO;
            held_v_reg <= 1'b0;
            hseen_reg  <= 1'b0;
            hbyte_reg  <= BYTE_ZERO;
            prefix_reg <= PREFIX_SHORT;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
        end else if (step) begin
            if (last_op) begin
                zdone_reg <= '0;
                bdone_reg <= 1'b0;
            end else if (do_zero) begin
                zdone_reg <= zdone_reg + ZCNT_W'(1);
            end else if (do_b) begin
                bdone_reg <= 1'b1;
            end
            if (do_tail && q_data.open_nal) begin
                prefix_reg <= q_data.is_long ? PREFIX_LONG : PREFIX_SHORT;
                hseen_reg  <= 1'b0;
                len_reg    <= '0;
                ovf_reg    <= 1'b0;
            end else if (emit) begin
                hseen_reg <= 1'b1;
                hbyte_reg <= hdr_next;
                len_reg   <= len_next;
                ovf_reg   <= ovf_reg || !len_lt;
            end
            if (do_zero || do_b) begin
                held_reg   <= do_zero ? BYTE_ZERO : q_data.data;
                held_v_reg <= 1'b1;
            end
            if (do_tail && q_data.finish) held_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (step && emit) begin
            ov_reg <= 1'b1;
        end else if (m_tready) begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_byte     <= held_reg;
            out_first    <= !hseen_reg;
            out_last     <= do_tail;
            out_len      <= len_next;
            out_prefix   <= prefix_reg;
            out_header   <= hdr_next;
            out_too_long <= ovf_reg || !len_lt;
            out_garbage  <= q_data.garbage;
        end
    end

    assign m_tvalid = ov_reg;

endmodule

FILE: hdl/annexb_nal_unit_splitter.sv
// Top level of the Annex B NAL unit splitter: front end, command queue, back end.
// Depends on anxb_pkg, anxb_front, anxb_queue and anxb_back.
//
//  channel  direction  handshake          payload
//  s_       in         s_tvalid/s_tready  tdata: stream_byte; tlast: end_of_stream
//  m_       out        m_tvalid/m_tready  tdata: NAL byte and fields; tlast: last_of_nal;
//                                         tuser: first_of_nal
//  cfg_     in         cfg_we             cfg_wdata: max_nal_len
//
// One input byte per cycle while the queue is not full. An item that releases held
// zeros or flushes at end of stream runs as separate back-end steps for its zero
// pushes, byte and tail; the command queue (QUEUE_DEPTH entries) absorbs these bursts.
// aresetn is synchronous and clears all control state at once, with no clearing pass.
// Output register decouples m_tready: input is stalled only when the queue is full.
module annexb_nal_unit_splitter #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [anxb_pkg::LEN_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,  // [7:0] stream_byte
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [7:0] payload_byte, [35:8] nal_length, [38:36] prefix_length,
    // [39] forbidden_zero, [41:40] reference_idc, [46:42] unit_type,
    // [47] too_long, [48] garbage_before, [55:49] zero
    output logic [55:0]                m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser   // [0] first_of_nal
);
    import anxb_pkg::*;

    anxb_cmd_t           wr_cmd, rd_cmd;
    logic                q_wr, q_full, q_rd, q_empty;
    logic [7:0]          o_byte, o_header;
    logic                o_first, o_last, o_too_long, o_garbage;
    logic [LEN_W-1:0]    o_len;
    logic [PREFIX_W-1:0] o_prefix;
    logic [7:0]          type_bits, forbid_bits;

    anxb_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_data   (wr_cmd)
    );

    anxb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (q_wr),
        .wr_data (wr_cmd),
        .full    (q_full),
        .rd      (q_rd),
        .empty   (q_empty),
        .rd_data (rd_cmd)
    );

    anxb_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_empty      (q_empty),
        .q_data       (rd_cmd),
        .q_rd         (q_rd),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_byte     (o_byte),
        .out_first    (o_first),
        .out_last     (o_last),
        .out_len      (o_len),
        .out_prefix   (o_prefix),
        .out_header   (o_header),
        .out_too_long (o_too_long),
        .out_garbage  (o_garbage)
    );

    assign type_bits   = o_header & TYPE_MASK;
    assign forbid_bits = o_header & FORBID_MASK;

    assign m_tdata = {7'd0, o_garbage, o_too_long, type_bits[4:0], o_header[6:5],
                      forbid_bits[7], o_prefix, o_len, o_byte};
    assign m_tlast = o_last;
    assign m_tuser = o_first;

endmodule
